FILE: sv/itoa_pkg.sv
// Package for the integer-to-text converter: state type, character and
// radix constants, digit glyph function. No dependencies.
`default_nettype none

package itoa_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BAD,
    ST_SIGN,
    ST_READ,
    ST_SHOW
  } state_e;

  localparam int unsigned RADIX_BITS  = 6;
  localparam int unsigned CHAR_BITS   = 7;
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd35;
  localparam logic [CHAR_BITS-1:0]  CHAR_MINUS  = 7'h2d;
  localparam logic [CHAR_BITS-1:0]  CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_BITS-1:0]  CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_BITS-1:0]  CHAR_ERROR  = 7'h00;
  localparam logic [RADIX_BITS-1:0] DECIMAL_DIGITS = 6'd10;

  function automatic logic [CHAR_BITS-1:0] digit_glyph(input logic [RADIX_BITS-1:0] d);
    logic [CHAR_BITS-1:0] code;
    if (d < DECIMAL_DIGITS) begin
      code = CHAR_ZERO + CHAR_BITS'(d);
    end else begin
      code = CHAR_LOWER_A + CHAR_BITS'(d - DECIMAL_DIGITS);
    end
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: sv/itoa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module itoa_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/integer_to_ascii_radix.sv
// Top level of the integer-to-text converter: bit-serial divider, digit RAM,
// character output register. Depends on itoa_pkg and itoa_ram.
//
// Usage:
//   Config channel (cfg_valid_i/cfg_ready_o/cfg_radix_i) sets the radix;
//   ready is always high and writes belong to idle periods. Reset radix: 10.
//   Input channel (in_valid_i/in_stall_o/number_i) takes one signed word.
//   Output channel (out_valid_o/out_stall_i) gives one character per
//   transfer, most significant first, '-' ahead of a negative value;
//   last_char_o flags the final one. A radix outside 2..35 gives one
//   transfer with bad_radix_o set, char_code_o zero and last_char_o set.
// Sequence:
//   A restoring divider shifts one quotient bit per cycle over the whole
//   word for each digit. Then '-' is loaded (ST_SIGN), and each digit is
//   read from the RAM (ST_READ) and loaded (ST_SHOW). A bad radix result
//   is loaded from ST_BAD once the output register is free.
// Stall: out_stall_i holds a valid output register and keeps the sequencer
//   waiting in ST_BAD, ST_SIGN and ST_SHOW; in_stall_o stays high until
//   the last character is loaded.
// Reset: asynchronous, clears the sequencer and output valid, radix to 10.
`default_nettype none

module integer_to_ascii_radix #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned MAX_CHARS = 33
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [itoa_pkg::RADIX_BITS-1:0]     cfg_radix_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [WORD_BITS-1:0]         number_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [itoa_pkg::CHAR_BITS-1:0]      char_code_o,
  output logic                                     last_char_o,
  output logic                                     bad_radix_o
);

  import itoa_pkg::*;

  localparam int unsigned AW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int unsigned CW = $clog2(WORD_BITS + 1);
  localparam int unsigned TW = $clog2(WORD_BITS + 2);
  localparam int unsigned EW = $clog2(MAX_CHARS + 1);
  localparam int unsigned XW = (TW > EW) ? TW : EW;

  state_e state_q, state_d;

  logic [RADIX_BITS-1:0] radix_q;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_BITS-1:0]  char_q, char_d;
  logic                  last_q, last_d;
  logic                  bad_q, bad_d;

  logic [WORD_BITS-1:0]  quot_q, quot_d;
  logic [RADIX_BITS-1:0] rem_q, rem_d;
  logic [AW-1:0]         bit_q, bit_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [EW-1:0]         left_q, left_d;
  logic                  neg_q, neg_d;

  logic                  in_xfer;
  logic                  out_free;
  logic                  radix_bad;
  logic [WORD_BITS-1:0]  num_u;
  logic [WORD_BITS-1:0]  mag;
  logic [RADIX_BITS:0]   rem_shift;
  logic                  rem_ge;
  logic [RADIX_BITS-1:0] rem_next;
  logic [WORD_BITS-1:0]  quot_step;
  logic                  digit_done;
  logic [CW-1:0]         cnt_inc;
  logic                  more_digits;
  logic [XW-1:0]         total;
  logic [EW-1:0]         emit_count;
  logic                  last_left;

  logic                  ram_we;
  logic                  ram_re;
  logic [RADIX_BITS-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign radix_bad   = (radix_q < RADIX_MIN) || (radix_q > RADIX_MAX);

  assign num_u = number_i;
  assign mag   = num_u[WORD_BITS-1] ? (~num_u + 1'b1) : num_u;

  assign rem_shift   = {rem_q, quot_q[WORD_BITS-1]};
  assign rem_ge      = rem_shift >= {1'b0, radix_q};
  assign rem_next    = rem_ge ? RADIX_BITS'(rem_shift - {1'b0, radix_q})
                              : RADIX_BITS'(rem_shift);
  assign quot_step   = {quot_q[WORD_BITS-2:0], rem_ge};
  assign digit_done  = (bit_q == AW'(WORD_BITS - 1));
  assign cnt_inc     = cnt_q + 1'b1;
  assign more_digits = (quot_step != '0) && (cnt_inc < CW'(WORD_BITS));
  assign total       = XW'(cnt_inc) + XW'(neg_q);
  assign emit_count  = (total > XW'(MAX_CHARS)) ? EW'(MAX_CHARS) : EW'(total);
  assign last_left   = (left_q == EW'(1));

  assign ram_we = (state_q == ST_DIV) && digit_done;
  assign ram_re = (state_q == ST_READ);

  itoa_ram #(
    .WIDTH(RADIX_BITS),
    .DEPTH(WORD_BITS)
  ) u_digit_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(rem_next),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = radix_bad ? ST_BAD : ST_DIV;
        end
      end
      ST_DIV: begin
        if (digit_done && !more_digits) begin
          state_d = neg_q ? ST_SIGN : ST_READ;
        end
      end
      ST_BAD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SIGN, ST_SHOW: begin
        if (out_free) begin
          state_d = last_left ? ST_IDLE : ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_SHOW;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    quot_d      = quot_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    left_d      = left_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    bad_d       = bad_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          quot_d = mag;
          neg_d  = num_u[WORD_BITS-1];
          rem_d  = '0;
          bit_d  = '0;
          cnt_d  = '0;
        end
      end
      ST_DIV: begin
        quot_d = quot_step;
        rem_d  = rem_next;
        bit_d  = bit_q + 1'b1;
        if (digit_done) begin
          rem_d  = '0;
          bit_d  = '0;
          cnt_d  = cnt_inc;
          idx_d  = cnt_q[AW-1:0];
          left_d = emit_count;
        end
      end
      ST_BAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_ERROR;
          last_d      = 1'b1;
          bad_d       = 1'b1;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_MINUS;
          last_d      = last_left;
          bad_d       = 1'b0;
          left_d      = left_q - 1'b1;
        end
      end
      ST_READ: begin
      end
      ST_SHOW: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = digit_glyph(ram_rdata);
          last_d      = last_left;
          bad_d       = 1'b0;
          left_d      = left_q - 1'b1;
          idx_d       = idx_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radix_q     <= RADIX_RESET;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
      cnt_q       <= '0;
      left_q      <= '0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bit_q       <= bit_d;
      cnt_q       <= cnt_d;
      left_q      <= left_d;
      neg_q       <= neg_d;
      if (cfg_valid_i && cfg_ready_o) begin
        radix_q <= cfg_radix_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
    bad_q  <= bad_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;
  assign bad_radix_o = bad_q;

endmodule

`default_nettype wire

FILE: sv/itoa_checker.sv
// Port-level checker for the integer-to-text converter, bound to the top
// level. Depends on itoa_pkg for widths and character codes.
`default_nettype none

module itoa_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [itoa_pkg::CHAR_BITS-1:0]  char_code_o,
  input wire logic                            last_char_o,
  input wire logic                            bad_radix_o
);

  import itoa_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_radix_o |-> last_char_o && (char_code_o == CHAR_ERROR))
    else $error("bad radix result is not a single zero code");

  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_radix_o |-> (char_code_o != CHAR_ERROR))
    else $error("character result carries a zero code");

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .char_code_o(char_code_o),
  .last_char_o(last_char_o),
  .bad_radix_o(bad_radix_o)
);

`default_nettype wire
